>>> src/gtd_pkg.sv
package gtd_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int RATIO_WIDTH = 24;
   localparam int FRAC_BITS   = 24;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = DIFF_WIDTH + RATIO_WIDTH + 1;
   localparam int QUOT_WIDTH  = PROD_WIDTH - FRAC_BITS;
   localparam int SUM_WIDTH   = QUOT_WIDTH + 1;

   localparam logic [RATIO_WIDTH-1:0] RATIO_RESET = 24'd10368890;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_ZERO = 1'b0;
   localparam logic KIND_ONE  = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic [RATIO_WIDTH-1:0]        ratio_type;

   typedef struct packed {
      logic      color;
      coord_type a_x;
      coord_type a_y;
      coord_type b_x;
      coord_type b_y;
      coord_type c_x;
      coord_type c_y;
   } req_type;

   typedef struct packed {
      logic      color;
      coord_type a_x;
      coord_type a_y;
      coord_type b_x;
      coord_type b_y;
      coord_type c_x;
      coord_type c_y;
      logic      last;
   } rsp_type;

   // one parent triangle with its split points already worked out
   typedef struct packed {
      logic      color;
      coord_type a_x;
      coord_type a_y;
      coord_type b_x;
      coord_type b_y;
      coord_type c_x;
      coord_type c_y;
      coord_type s1_x;
      coord_type s1_y;
      coord_type s2_x;
      coord_type s2_y;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic                 empty;
      logic [CNT_WIDTH-1:0] count;
   } qstat_type;

   typedef enum logic [1:0] {
      CHILD_FIRST,
      CHILD_SECOND,
      CHILD_THIRD
   } child_type;

   function automatic diff_type coord_diff(input coord_type v, input coord_type u);
      diff_type d;
      d = {v[COORD_WIDTH-1], v} - {u[COORD_WIDTH-1], u};
      return d;
   endfunction

   // round to nearest (ties up), add the base point, clamp to coordinate range
   function automatic coord_type split_finish(input prod_type p, input coord_type u);
      prod_type                     r;
      logic [QUOT_WIDTH-1:0]        q;
      logic [SUM_WIDTH-1:0]         s;
      logic [SUM_WIDTH-COORD_WIDTH:0] top;
      coord_type                    res;
      r   = p + {{(PROD_WIDTH-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
      q   = r[PROD_WIDTH-1:FRAC_BITS];
      s   = {q[QUOT_WIDTH-1], q} + {{(SUM_WIDTH-COORD_WIDTH){u[COORD_WIDTH-1]}}, u};
      top = s[SUM_WIDTH-1:COORD_WIDTH-1];
      if (top == '0 || top == '1) begin
         res = s[COORD_WIDTH-1:0];
      end else if (s[SUM_WIDTH-1]) begin
         res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

>>> src/gtd_front.sv
module gtd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gtd_pkg::req_type   req_data,
   input  gtd_pkg::ratio_type inv_ratio,
   input  gtd_pkg::qstat_type q_stat,
   output gtd_pkg::push_type  push
);

   logic                       v1_ff, v1_in;
   logic                       v2_ff, v2_in;
   gtd_pkg::req_type           item1_ff;
   gtd_pkg::req_type           item2_ff;
   gtd_pkg::diff_type          d_ff [4];
   gtd_pkg::diff_type          d_in [4];
   gtd_pkg::prod_type          p_ff [4];
   gtd_pkg::prod_type          p_in [4];
   logic [gtd_pkg::CNT_WIDTH:0] used;
   logic                       accept;
   gtd_pkg::coord_type         u1_x, u1_y, v1_x, v1_y;
   gtd_pkg::prod_type          ratio_ext;

   // credit check: queue entries plus items still in the pipe
   always_comb begin
      used      = {1'b0, q_stat.count} + (gtd_pkg::CNT_WIDTH + 1)'(v1_ff)
                  + (gtd_pkg::CNT_WIDTH + 1)'(v2_ff);
      req_ready = !reset && (used < (gtd_pkg::CNT_WIDTH + 1)'(gtd_pkg::QUEUE_DEPTH));
      accept    = req_valid && req_ready;
      v1_in     = accept;
      v2_in     = v1_ff;
   end

   // first split: P = split(A,B) for kind 0, Q = split(B,A) for kind 1
   always_comb begin
      if (req_data.color == gtd_pkg::KIND_ONE) begin
         u1_x = req_data.b_x;
         u1_y = req_data.b_y;
         v1_x = req_data.a_x;
         v1_y = req_data.a_y;
      end else begin
         u1_x = req_data.a_x;
         u1_y = req_data.a_y;
         v1_x = req_data.b_x;
         v1_y = req_data.b_y;
      end
      d_in[0] = gtd_pkg::coord_diff(v1_x, u1_x);
      d_in[1] = gtd_pkg::coord_diff(v1_y, u1_y);
      d_in[2] = gtd_pkg::coord_diff(req_data.c_x, req_data.b_x);
      d_in[3] = gtd_pkg::coord_diff(req_data.c_y, req_data.b_y);
   end

   always_comb begin
      ratio_ext = gtd_pkg::prod_type'($signed({1'b0, inv_ratio}));
      for (int i = 0; i < 4; i++) begin
         p_in[i] = gtd_pkg::prod_type'(d_ff[i]) * ratio_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      item1_ff <= req_data;
      item2_ff <= item1_ff;
      for (int i = 0; i < 4; i++) begin
         d_ff[i] <= d_in[i];
         p_ff[i] <= p_in[i];
      end
   end

   always_comb begin
      push.valid       = v2_ff;
      push.entry.color = item2_ff.color;
      push.entry.a_x   = item2_ff.a_x;
      push.entry.a_y   = item2_ff.a_y;
      push.entry.b_x   = item2_ff.b_x;
      push.entry.b_y   = item2_ff.b_y;
      push.entry.c_x   = item2_ff.c_x;
      push.entry.c_y   = item2_ff.c_y;
      if (item2_ff.color == gtd_pkg::KIND_ONE) begin
         push.entry.s1_x = gtd_pkg::split_finish(p_ff[0], item2_ff.b_x);
         push.entry.s1_y = gtd_pkg::split_finish(p_ff[1], item2_ff.b_y);
      end else begin
         push.entry.s1_x = gtd_pkg::split_finish(p_ff[0], item2_ff.a_x);
         push.entry.s1_y = gtd_pkg::split_finish(p_ff[1], item2_ff.a_y);
      end
      push.entry.s2_x = gtd_pkg::split_finish(p_ff[2], item2_ff.b_x);
      push.entry.s2_y = gtd_pkg::split_finish(p_ff[3], item2_ff.b_y);
   end

endmodule

>>> src/gtd_queue.sv
module gtd_queue (
   input  logic                clock,
   input  logic                reset,
   input  gtd_pkg::push_type   push,
   input  logic                pop,
   output gtd_pkg::entry_type  head,
   output gtd_pkg::qstat_type  q_stat
);

   gtd_pkg::entry_type               mem [gtd_pkg::QUEUE_DEPTH];
   logic [gtd_pkg::PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [gtd_pkg::PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [gtd_pkg::CNT_WIDTH-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == gtd_pkg::PTR_WIDTH'(gtd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == gtd_pkg::PTR_WIDTH'(gtd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
      head         = mem[rd_ptr_ff];
      q_stat.count = count_ff;
      q_stat.empty = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

>>> src/gtd_back.sv
module gtd_back (
   input  logic               clock,
   input  logic               reset,
   input  gtd_pkg::entry_type head,
   input  gtd_pkg::qstat_type q_stat,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output gtd_pkg::rsp_type   rsp_data
);

   gtd_pkg::child_type k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   gtd_pkg::rsp_type   rsp_ff, rsp_in;
   logic               load;
   logic               last_child;

   always_comb begin
      load   = !q_stat.empty && (!rsp_valid_ff || rsp_ready);
      rsp_in = '0;
      if (head.color == gtd_pkg::KIND_ONE) begin
         last_child = (k_ff == gtd_pkg::CHILD_THIRD);
         unique case (k_ff)
            gtd_pkg::CHILD_FIRST: begin
               rsp_in = {gtd_pkg::KIND_ONE, head.s2_x, head.s2_y, head.c_x, head.c_y,
                         head.a_x, head.a_y, 1'b0};
            end
            gtd_pkg::CHILD_SECOND: begin
               rsp_in = {gtd_pkg::KIND_ONE, head.s1_x, head.s1_y, head.s2_x, head.s2_y,
                         head.b_x, head.b_y, 1'b0};
            end
            gtd_pkg::CHILD_THIRD: begin
               rsp_in = {gtd_pkg::KIND_ZERO, head.s2_x, head.s2_y, head.s1_x, head.s1_y,
                         head.a_x, head.a_y, 1'b1};
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end else begin
         last_child = (k_ff == gtd_pkg::CHILD_SECOND);
         unique case (k_ff)
            gtd_pkg::CHILD_FIRST: begin
               rsp_in = {gtd_pkg::KIND_ZERO, head.c_x, head.c_y, head.s1_x, head.s1_y,
                         head.b_x, head.b_y, 1'b0};
            end
            gtd_pkg::CHILD_SECOND: begin
               rsp_in = {gtd_pkg::KIND_ONE, head.s1_x, head.s1_y, head.c_x, head.c_y,
                         head.a_x, head.a_y, 1'b1};
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
      pop = load && last_child;
      k_in = k_ff;
      if (load) begin
         unique case (k_ff)
            gtd_pkg::CHILD_FIRST:  k_in = last_child ? gtd_pkg::CHILD_FIRST : gtd_pkg::CHILD_SECOND;
            gtd_pkg::CHILD_SECOND: k_in = last_child ? gtd_pkg::CHILD_FIRST : gtd_pkg::CHILD_THIRD;
            default:               k_in = gtd_pkg::CHILD_FIRST;
         endcase
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= gtd_pkg::CHILD_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/golden_triangle_deflation.sv
// One Penrose deflation step on Robinson triangles. A kind-0 triangle yields two
// children, a kind-1 triangle three, one child per cycle from the output register
// while rsp_ready is high, which sets the sustained rate. The front end subtracts,
// multiplies by inv_ratio and rounds/saturates in a pipe through d_ff and p_ff and
// files each parent into a 4-entry queue, so it keeps taking triangles while
// children drain and queue credit remains.
// inv_ratio may be written only while the block is empty.
module golden_triangle_deflation (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gtd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gtd_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [gtd_pkg::RATIO_WIDTH-1:0] csr_wdata
);

   gtd_pkg::ratio_type inv_ratio_ff, inv_ratio_in;
   gtd_pkg::push_type  push;
   gtd_pkg::qstat_type q_stat;
   gtd_pkg::entry_type head;
   logic               pop;

   always_comb begin
      csr_ready    = !reset;
      inv_ratio_in = (csr_valid && csr_ready) ? csr_wdata : inv_ratio_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ratio_ff <= gtd_pkg::RATIO_RESET;
      end else begin
         inv_ratio_ff <= inv_ratio_in;
      end
   end

   gtd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .inv_ratio (inv_ratio_ff),
      .q_stat    (q_stat),
      .push      (push)
   );

   gtd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .q_stat (q_stat)
   );

   gtd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // credit scheme must keep the queue from overflowing
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= gtd_pkg::CNT_WIDTH'(gtd_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

   // every queue write comes from an input transaction carried through the v1 and v2 pipe registers
   a_push_latency: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> $past(req_valid && req_ready, 2))
      else $error("queue write without matching input transaction");

   // siblings of one parent leave back to back
   a_sibling_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid)
      else $error("gap after a non-final child");

endmodule

>>> tb/golden_triangle_deflation_tb.sv
module golden_triangle_deflation_tb;

   import gtd_pkg::*;

   localparam int PHASES          = 6;
   localparam int TRIS_PER_PHASE  = 60;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 400000;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   req_type   req_data = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   rsp_type   rsp_data;
   logic      csr_valid = 1'b0;
   logic      csr_ready;
   ratio_type csr_wdata = '0;

   req_type   pending_tris[$];
   rsp_type   children_due[$];
   ratio_type cur_ratio = RATIO_RESET;

   bit idle_on  = 1'b1;
   bit hold_req = 1'b0;
   int req_gap_left   = 0;
   int rsp_stall_left = 0;
   int cycle_count    = 0;
   int mismatches     = 0;
   int tris_accepted  = 0;
   int kind0_tris     = 0;
   int kind1_tris     = 0;
   int children_seen  = 0;
   int ratio_writes   = 0;

   golden_triangle_deflation dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // point base + (toward - base) * ratio, rounded half up, clamped
   function automatic coord_type split_point(input coord_type base, input coord_type toward,
                                             input ratio_type ratio);
      longint span;
      longint scaled;
      longint sum;
      span   = longint'(toward) - longint'(base);
      scaled = (span * longint'(ratio) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      sum    = longint'(base) + scaled;
      if (sum > longint'(COORD_MAX)) sum = longint'(COORD_MAX);
      if (sum < longint'(COORD_MIN)) sum = longint'(COORD_MIN);
      return coord_type'(sum);
   endfunction

   function automatic rsp_type child(input logic kind, input coord_type ax, input coord_type ay,
                                     input coord_type bx, input coord_type by,
                                     input coord_type cx, input coord_type cy, input logic fin);
      rsp_type c;
      c.color = kind;
      c.a_x   = ax;
      c.a_y   = ay;
      c.b_x   = bx;
      c.b_y   = by;
      c.c_x   = cx;
      c.c_y   = cy;
      c.last  = fin;
      return c;
   endfunction

   task automatic predict_children(input req_type t);
      coord_type px, py, qx, qy, rx, ry;
      tris_accepted++;
      if (t.color == KIND_ZERO) begin
         kind0_tris++;
         px = split_point(t.a_x, t.b_x, cur_ratio);
         py = split_point(t.a_y, t.b_y, cur_ratio);
         children_due.push_back(child(KIND_ZERO, t.c_x, t.c_y, px, py, t.b_x, t.b_y, 1'b0));
         children_due.push_back(child(KIND_ONE, px, py, t.c_x, t.c_y, t.a_x, t.a_y, 1'b1));
      end else begin
         kind1_tris++;
         qx = split_point(t.b_x, t.a_x, cur_ratio);
         qy = split_point(t.b_y, t.a_y, cur_ratio);
         rx = split_point(t.b_x, t.c_x, cur_ratio);
         ry = split_point(t.b_y, t.c_y, cur_ratio);
         children_due.push_back(child(KIND_ONE, rx, ry, t.c_x, t.c_y, t.a_x, t.a_y, 1'b0));
         children_due.push_back(child(KIND_ONE, qx, qy, rx, ry, t.b_x, t.b_y, 1'b0));
         children_due.push_back(child(KIND_ZERO, rx, ry, qx, qy, t.a_x, t.a_y, 1'b1));
      end
   endtask

   // mostly back-to-back, sometimes a short gap, rarely a long hole; no gap while idle_on is clear
   function automatic int gap_length();
      int unsigned pick;
      if (!idle_on) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic coord_type rand_coord();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      if (pick <= 2) return coord_type'(int'($urandom_range(0, 256)) - 128);
      return coord_type'($urandom);
   endfunction

   task automatic push_tri(input logic kind, input coord_type ax, input coord_type ay,
                           input coord_type bx, input coord_type by,
                           input coord_type cx, input coord_type cy);
      req_type t;
      t.color = kind;
      t.a_x   = ax;
      t.a_y   = ay;
      t.b_x   = bx;
      t.b_y   = by;
      t.c_x   = cx;
      t.c_y   = cy;
      pending_tris.push_back(t);
   endtask

   task automatic check_field(input string name, input logic [COORD_WIDTH-1:0] want,
                              input logic [COORD_WIDTH-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // sampled at the falling edge so nothing races the drivers
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_tris.size() != 0 || req_valid || children_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_ratio(input ratio_type value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      cur_ratio = value;
      ratio_writes++;
   endtask

   always @(posedge clock) begin : feed_req
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_valid && req_ready) predict_children(req_data);
         if (!req_valid || req_ready) begin
            next_valid = 1'b0;
            if (req_gap_left > 0) begin
               req_gap_left--;
            end else if (pending_tris.size() != 0 && !hold_req) begin
               req_data <= pending_tris.pop_front();
               next_valid = 1'b1;
               req_gap_left = gap_length();
            end
            req_valid <= next_valid;
         end
      end
   end

   always @(posedge clock) begin : drain_rsp
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = 0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall_left = gap_length();
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         children_seen++;
         if (children_due.size() == 0) begin
            mismatches++;
            $display("%0t: child with no transaction outstanding: expected none, actual %h",
                     $time, rsp_data);
         end else begin
            want = children_due.pop_front();
            check_field("color", want.color, rsp_data.color);
            check_field("a_x", want.a_x, rsp_data.a_x);
            check_field("a_y", want.a_y, rsp_data.a_y);
            check_field("b_x", want.b_x, rsp_data.b_x);
            check_field("b_y", want.b_y, rsp_data.b_y);
            check_field("c_x", want.c_x, rsp_data.c_x);
            check_field("c_y", want.c_y, rsp_data.c_y);
            check_field("last", want.last, rsp_data.last);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d children still outstanding", $time,
                  children_due.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      ratio_type phase_ratio [PHASES];
      phase_ratio[0] = RATIO_RESET;
      phase_ratio[1] = '0;
      phase_ratio[2] = '1;
      phase_ratio[3] = 24'h800000;   // exact halves: rounding ties
      phase_ratio[4] = ratio_type'($urandom);
      phase_ratio[5] = ratio_type'($urandom);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // corners under the reset ratio, both kinds
      for (int k = 0; k < 2; k++) begin
         push_tri(k[0], 0, 0, 0, 0, 0, 0);
         push_tri(k[0], COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
         push_tri(k[0], COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
         push_tri(k[0], COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 0, 0);
         push_tri(k[0], COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
         push_tri(k[0], -1, 1, 1, -1, -1, 1);
         push_tri(k[0], 24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555,
                  24'h400000, 24'hC00000);
         push_tri(k[0], 1, 0, 0, 1, 2, -3);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph != 0) begin
            wait_drained();
            write_ratio(phase_ratio[ph]);
         end
         idle_on = (ph != 2);
         repeat (TRIS_PER_PHASE) begin
            push_tri($urandom_range(0, 1), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord());
         end
         if (ph == 3) begin
            // hold the sender mid-phase until the output has fully drained
            while (tris_accepted < 16 + 3 * TRIS_PER_PHASE + 25) @(negedge clock);
            hold_req = 1'b1;
            while (req_valid || children_due.size() != 0) @(negedge clock);
            hold_req = 1'b0;
         end
      end

      wait_drained();
      $display("run covered %0d triangles (%0d kind 0, %0d kind 1), %0d children checked",
               tris_accepted, kind0_tris, kind1_tris, children_seen);
      $display("ratio written %0d times, including zero, all-ones and the half point",
               ratio_writes);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
src/gtd_pkg.sv
src/gtd_front.sv
src/gtd_queue.sv
src/gtd_back.sv
src/golden_triangle_deflation.sv
tb/golden_triangle_deflation_tb.sv
